// ----- rtl/ldf_pkg.sv -----
package ldf_pkg;

   localparam int MAX_PAYLOAD  = 2048;
   localparam int HEADER_BYTES = 4;
   localparam int BYTE_WIDTH   = 8;
   localparam int LEN_WIDTH    = 12;
   localparam int TOTAL_WIDTH  = 16;
   localparam int KIND_WIDTH   = 3;
   localparam int REMAIN_WIDTH = $clog2(MAX_PAYLOAD + 1);
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_LEAD  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_LEAD = 2'd1;

   localparam logic [BYTE_WIDTH-1:0] FIRST_LEAD_RESET  = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] SECOND_LEAD_RESET = 8'h00;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEAD2,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_TRAIL,
      PH_SKIP
   } phase_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PAYLOAD,
      KIND_SUM_OK,
      KIND_SUM_BAD,
      KIND_BAD_LEAD,
      KIND_BAD_LENGTH,
      KIND_EARLY_END,
      KIND_CLEAN_END
   } kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] in_byte;
      logic                  end_of_input;
   } req_beat_type;

   typedef struct packed {
      kind_type              result_kind;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic [LEN_WIDTH-1:0]  payload_length;
   } rsp_beat_type;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [BYTE_WIDTH-1:0]      wdata;
   } csr_write_type;

endpackage

// ----- rtl/ldf_req_if.sv -----
interface ldf_req_if;
   logic                          valid;
   logic                          ready;
   logic [ldf_pkg::BYTE_WIDTH-1:0] in_byte;
   logic                          end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/ldf_rsp_if.sv -----
interface ldf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ldf_pkg::KIND_WIDTH-1:0] result_kind;
   logic [ldf_pkg::BYTE_WIDTH-1:0] payload_byte;
   logic [ldf_pkg::LEN_WIDTH-1:0]  payload_length;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_length, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_length, output ready);
endinterface

// ----- rtl/ldf_csr_if.sv -----
interface ldf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ldf_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ldf_pkg::BYTE_WIDTH-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/ldf_in_stage.sv -----
module ldf_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ldf_pkg::req_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ldf_pkg::req_beat_type out_beat
);
   import ldf_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;
   logic         take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= in_beat;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;
endmodule

// ----- rtl/ldf_core.sv -----
module ldf_core (
   input  logic                   clock,
   input  logic                   reset,
   input  ldf_pkg::csr_write_type csr_write,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ldf_pkg::req_beat_type  in_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ldf_pkg::rsp_beat_type  rsp_beat
);
   import ldf_pkg::*;

   localparam logic [TOTAL_WIDTH-1:0] HDR_TOTAL = TOTAL_WIDTH'(HEADER_BYTES);
   localparam logic [TOTAL_WIDTH-1:0] MAX_TOTAL = TOTAL_WIDTH'(MAX_PAYLOAD);

   phase_type                phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0]    lead1_ff, lead2_ff;
   logic [BYTE_WIDTH-1:0]    len_lo_ff, len_lo_in;
   logic [LEN_WIDTH-1:0]     plen_ff, plen_in;
   logic [REMAIN_WIDTH-1:0]  remain_ff, remain_in;
   logic [BYTE_WIDTH-1:0]    sum_ff, sum_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_beat_type             out_beat_ff, out_beat_in;

   logic                     fire;
   logic                     emit;
   logic [BYTE_WIDTH-1:0]    b;
   logic [BYTE_WIDTH-1:0]    sum_add;
   logic [TOTAL_WIDTH-1:0]   total;
   logic [TOTAL_WIDTH-1:0]   count;
   logic [REMAIN_WIDTH-1:0]  remain_dec;

   assign in_ready   = !out_valid_ff || rsp_ready;
   assign fire       = in_valid && in_ready;
   assign b          = in_beat.in_byte;
   assign sum_add    = sum_ff + b;
   assign total      = {b, len_lo_ff};
   assign count      = total - HDR_TOTAL;
   assign remain_dec = (remain_ff == '0) ? '0 : remain_ff - 1'b1;

   // step of the record parser
   always_comb begin
      phase_in    = phase_ff;
      len_lo_in   = len_lo_ff;
      plen_in     = plen_ff;
      remain_in   = remain_ff;
      sum_in      = sum_ff;
      emit        = 1'b0;
      out_beat_in = '{result_kind: KIND_PAYLOAD, payload_byte: '0, payload_length: '0};
      if (fire) begin
         if (in_beat.end_of_input) begin
            emit = 1'b1;
            out_beat_in.result_kind = (phase_ff == PH_HUNT) ? KIND_CLEAN_END : KIND_EARLY_END;
            phase_in  = PH_HUNT;
            remain_in = '0;
            sum_in    = '0;
         end else begin
            sum_in = sum_add;
            case (phase_ff)
               PH_HUNT: begin
                  if (b == '0) begin
                     sum_in = '0;
                  end else begin
                     sum_in = b;
                     if (b == lead1_ff) begin
                        phase_in = PH_LEAD2;
                     end else begin
                        phase_in  = PH_SKIP;
                        remain_in = REMAIN_WIDTH'(HEADER_BYTES - 1);
                     end
                  end
               end
               PH_LEAD2: begin
                  if (b == lead2_ff) begin
                     phase_in = PH_LEN_LO;
                  end else begin
                     phase_in  = PH_SKIP;
                     remain_in = REMAIN_WIDTH'(HEADER_BYTES - 2);
                  end
               end
               PH_LEN_LO: begin
                  len_lo_in = b;
                  phase_in  = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  if (total < HDR_TOTAL || count > MAX_TOTAL) begin
                     emit = 1'b1;
                     out_beat_in.result_kind = KIND_BAD_LENGTH;
                     phase_in = PH_HUNT;
                     sum_in   = '0;
                  end else begin
                     remain_in = count[REMAIN_WIDTH-1:0];
                     plen_in   = count[LEN_WIDTH-1:0];
                     phase_in  = (count == '0) ? PH_TRAIL : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  remain_in = remain_dec;
                  if (remain_dec == '0) begin
                     phase_in = PH_TRAIL;
                  end
                  emit = 1'b1;
                  out_beat_in.result_kind  = KIND_PAYLOAD;
                  out_beat_in.payload_byte = b;
               end
               PH_TRAIL: begin
                  emit = 1'b1;
                  out_beat_in.result_kind    = (sum_add == '0) ? KIND_SUM_OK : KIND_SUM_BAD;
                  out_beat_in.payload_length = plen_ff;
                  phase_in = PH_HUNT;
                  sum_in   = '0;
               end
               PH_SKIP: begin
                  remain_in = remain_dec;
                  if (remain_dec == '0) begin
                     emit = 1'b1;
                     out_beat_in.result_kind = KIND_BAD_LEAD;
                     phase_in = PH_HUNT;
                     sum_in   = '0;
                  end
               end
               default: begin
                  phase_in  = PH_HUNT;
                  sum_in    = '0;
                  remain_in = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (in_ready) begin
         out_valid_in = fire && emit;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_lo_ff    <= '0;
         plen_ff      <= '0;
         remain_ff    <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         lead1_ff     <= FIRST_LEAD_RESET;
         lead2_ff     <= SECOND_LEAD_RESET;
      end else begin
         len_lo_ff    <= len_lo_in;
         plen_ff      <= plen_in;
         remain_ff    <= remain_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         if (csr_write.valid && csr_write.index == CSR_FIRST_LEAD) begin
            lead1_ff <= csr_write.wdata;
         end
         if (csr_write.valid && csr_write.index == CSR_SECOND_LEAD) begin
            lead2_ff <= csr_write.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_beat_ff <= out_beat_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != '0)
      else $error("payload phase with no bytes due");

   a_skip_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> (remain_ff == REMAIN_WIDTH'(1) || remain_ff == REMAIN_WIDTH'(2)
                               || remain_ff == REMAIN_WIDTH'(3)))
      else $error("skip count out of range");

   a_end_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      fire && in_beat.end_of_input |=> phase_ff == PH_HUNT && sum_ff == '0
                                       && out_valid_ff)
      else $error("end marker did not reset the parser");

   a_payload_beat_out: assert property (@(posedge clock) disable iff (reset)
      fire && !in_beat.end_of_input && phase_ff == PH_PAYLOAD
      |=> out_valid_ff && out_beat_ff.result_kind == KIND_PAYLOAD)
      else $error("payload byte not passed out");

   a_length_only_on_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.result_kind != KIND_SUM_OK
      && out_beat_ff.result_kind != KIND_SUM_BAD |-> out_beat_ff.payload_length == '0)
      else $error("length reported outside record end");
endmodule

// ----- rtl/loader_record_deframer.sv -----
// an accepted beat passes the input register and the parser; any result is registered
// throughput: one beat per cycle while results are taken, set by the parser step
//   between the input and result registers; a stalled result holds one more beat upstream
// reset: synchronous, active high; parser back to hunting, sum and counters cleared,
//   lead bytes to 1 and 0, no beat held in either register
module loader_record_deframer (
   input logic clock,
   input logic reset,
   ldf_req_if.sink   req_port,
   ldf_rsp_if.source rsp_port,
   ldf_csr_if.sink   csr_port
);
   import ldf_pkg::*;

   // request beat packed for the input register
   req_beat_type  req_beat;
   // input register towards the parser
   logic          stage_valid;
   logic          stage_ready;
   req_beat_type  stage_beat;
   // result register
   logic          rsp_valid;
   rsp_beat_type  rsp_beat;
   // register write, always taken
   csr_write_type csr_write;

   assign req_beat.in_byte      = req_port.in_byte;
   assign req_beat.end_of_input = req_port.end_of_input;

   // writes go straight to the lead registers, so the write channel never stalls
   assign csr_port.ready  = 1'b1;
   assign csr_write.valid = csr_port.valid;
   assign csr_write.index = csr_port.index;
   assign csr_write.wdata = csr_port.wdata;

   // input register: parts the request side from the parser
   ldf_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_beat   (req_beat),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_beat  (stage_beat)
   );

   // parser state, lead registers and result register
   ldf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_beat   (stage_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready),
      .rsp_beat  (rsp_beat)
   );

   // result beat out to the response channel
   assign rsp_port.valid          = rsp_valid;
   assign rsp_port.result_kind    = rsp_beat.result_kind;
   assign rsp_port.payload_byte   = rsp_beat.payload_byte;
   assign rsp_port.payload_length = rsp_beat.payload_length;
endmodule
